// ===== sv/pf_pkg.sv =====
// shared constants, types and sequencer states for the prime factorizer
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

    localparam int VALUE_WIDTH = 24;
    localparam int EXP_W       = 5;
    localparam int MAX_RESULTS = 8;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);

    localparam logic [EXP_W-1:0] EXP_MAX = '1;

    typedef logic [VALUE_WIDTH-1:0] pf_word_t;

    typedef struct packed {
        logic     start;
        pf_word_t dividend;
        pf_word_t divisor;
    } pf_div_req_t;

    typedef struct packed {
        logic     busy;
        logic     done;
        pf_word_t quotient;
        pf_word_t remainder;
    } pf_div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_PUSH,
        S_FINAL,
        S_FLUSH,
        S_ZERO
    } pf_state_t;

endpackage

`default_nettype wire

// ===== sv/pf_divider.sv =====
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pf_divider
    import pf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire pf_div_req_t req,
    output pf_div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    pf_word_t             part_reg, part_next;
    pf_word_t             quo_reg, quo_next;
    pf_word_t             dsor_reg, dsor_next;

    logic [VALUE_WIDTH:0] shifted;
    logic [VALUE_WIDTH:0] diff;
    logic                 ge;

    always_comb begin
        shifted = {part_reg, quo_reg[VALUE_WIDTH-1]};
        diff    = shifted - {1'b0, dsor_reg};
        ge      = (shifted >= {1'b0, dsor_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        part_next = part_reg;
        quo_next  = quo_reg;
        dsor_next = dsor_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            part_next = '0;
            quo_next  = req.dividend;
            dsor_next = req.divisor;
        end else if (busy_reg) begin
            part_next = ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            quo_next  = {quo_reg[VALUE_WIDTH-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(VALUE_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        part_reg <= part_next;
        quo_reg  <= quo_next;
        dsor_reg <= dsor_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = part_reg;

endmodule

`default_nettype wire

// ===== sv/prime_factorizer.sv =====
// prime factorizer top level: trial-division sequencer, result holding and output register
//
//  channel | direction | beat contents                                   | handshake
//  s_      | in        | value                                           | s_valid / s_ready
//  m_      | out       | prime_factor, exponent, no_factors, last_factor | m_valid / m_ready
//
// each trial divisor costs one serial division plus the S_START and S_WAIT sequencing;
// a divisor that divides costs one extra division per multiplicity; 0 and 1 take no division
// s_ready is high only when the sequencer is idle; aresetn is synchronous active low
// a stalled m_ channel holds the search whenever a new factor finds both the held slot and the output full
`timescale 1ns / 1ps
`default_nettype none

module prime_factorizer
    import pf_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_value,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [VALUE_WIDTH-1:0]      m_prime_factor,
    output logic [EXP_W-1:0]            m_exponent,
    output logic                        m_no_factors,
    output logic                        m_last_factor
);

    pf_state_t state_reg, state_next;

    // working values of the search
    pf_word_t           rem_reg, rem_next;
    pf_word_t           dvsr_reg, dvsr_next;
    logic [EXP_W-1:0]   mult_reg, mult_next;
    logic               inner_reg, inner_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // freshly found factor, waiting to go into the holding slot
    pf_word_t           cand_prime_reg, cand_prime_next;
    logic [EXP_W-1:0]   cand_exp_reg, cand_exp_next;
    logic               cand_final_reg, cand_final_next;

    // one factor held back until we know whether it is the last one
    pf_word_t           pend_prime_reg, pend_prime_next;
    logic [EXP_W-1:0]   pend_exp_reg, pend_exp_next;
    logic               pend_valid_reg, pend_valid_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    pf_word_t           m_prime_reg, m_prime_next;
    logic [EXP_W-1:0]   m_exp_reg, m_exp_next;
    logic               m_nof_reg, m_nof_next;
    logic               m_last_reg, m_last_next;

    pf_div_req_t div_req;
    pf_div_rsp_t div_rsp;

    logic out_free;
    logic push_go;
    logic rem_zero;
    logic past_root;

    pf_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign push_go   = !pend_valid_reg || out_free;
    assign rem_zero  = (div_rsp.remainder == '0);
    assign past_root = (dvsr_reg > div_rsp.quotient);

    assign div_req.start    = (state_reg == S_START);
    assign div_req.dividend = rem_reg;
    assign div_req.divisor  = dvsr_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_value <= pf_word_t'(1)) ? S_ZERO : S_START;
                end
            end
            S_START: state_next = S_WAIT;
            S_WAIT: begin
                if (div_rsp.done) begin
                    if (inner_reg) begin
                        state_next = rem_zero ? S_START : S_PUSH;
                    end else if (past_root) begin
                        state_next = S_FINAL;
                    end else begin
                        state_next = S_START;
                    end
                end
            end
            S_PUSH: begin
                if (push_go) begin
                    if (cand_final_reg || count_reg == COUNT_W'(MAX_RESULTS - 1)) begin
                        state_next = S_FLUSH;
                    end else begin
                        state_next = S_START;
                    end
                end
            end
            S_FINAL: begin
                if (count_reg < COUNT_W'(MAX_RESULTS) && rem_reg > pf_word_t'(1)) begin
                    state_next = S_PUSH;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        rem_next        = rem_reg;
        dvsr_next       = dvsr_reg;
        mult_next       = mult_reg;
        inner_next      = inner_reg;
        count_next      = count_reg;
        cand_prime_next = cand_prime_reg;
        cand_exp_next   = cand_exp_reg;
        cand_final_next = cand_final_reg;
        pend_prime_next = pend_prime_reg;
        pend_exp_next   = pend_exp_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_prime_next    = m_prime_reg;
        m_exp_next      = m_exp_reg;
        m_nof_next      = m_nof_reg;
        m_last_next     = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    rem_next        = s_value;
                    dvsr_next       = pf_word_t'(2);
                    mult_next       = '0;
                    inner_next      = 1'b0;
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                end
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    if (inner_reg) begin
                        if (rem_zero) begin
                            // keep dividing this prime out
                            rem_next  = div_rsp.quotient;
                            mult_next = (mult_reg == EXP_MAX) ? EXP_MAX : mult_reg + 1'b1;
                        end else begin
                            cand_prime_next = dvsr_reg;
                            cand_exp_next   = mult_reg;
                            cand_final_next = 1'b0;
                            inner_next      = 1'b0;
                        end
                    end else if (!past_root) begin
                        if (rem_zero) begin
                            rem_next   = div_rsp.quotient;
                            mult_next  = EXP_W'(1);
                            inner_next = 1'b1;
                        end else begin
                            dvsr_next = dvsr_reg + 1'b1;
                        end
                    end
                end
            end
            S_PUSH: begin
                if (push_go) begin
                    // the held factor is known not to be last once another turns up
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_prime_next = pend_prime_reg;
                        m_exp_next   = pend_exp_reg;
                        m_nof_next   = 1'b0;
                        m_last_next  = 1'b0;
                    end
                    pend_prime_next = cand_prime_reg;
                    pend_exp_next   = cand_exp_reg;
                    pend_valid_next = 1'b1;
                    count_next      = count_reg + 1'b1;
                    dvsr_next       = dvsr_reg + 1'b1;
                end
            end
            S_FINAL: begin
                // leftover above one is itself prime
                cand_prime_next = rem_reg;
                cand_exp_next   = EXP_W'(1);
                cand_final_next = 1'b1;
                mult_next       = EXP_W'(1);
            end
            S_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_prime_next    = pend_prime_reg;
                    m_exp_next      = pend_exp_reg;
                    m_nof_next      = 1'b0;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_prime_next = '0;
                    m_exp_next   = '0;
                    m_nof_next   = 1'b1;
                    m_last_next  = 1'b1;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            inner_reg      <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            cand_final_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            inner_reg      <= inner_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            cand_final_reg <= cand_final_next;
        end
        rem_reg        <= rem_next;
        dvsr_reg       <= dvsr_next;
        mult_reg       <= mult_next;
        cand_prime_reg <= cand_prime_next;
        cand_exp_reg   <= cand_exp_next;
        pend_prime_reg <= pend_prime_next;
        pend_exp_reg   <= pend_exp_next;
        m_prime_reg    <= m_prime_next;
        m_exp_reg      <= m_exp_next;
        m_nof_reg      <= m_nof_next;
        m_last_reg     <= m_last_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_prime_factor = m_prime_reg;
    assign m_exponent     = m_exp_reg;
    assign m_no_factors   = m_nof_reg;
    assign m_last_factor  = m_last_reg;

    // divider is never left running once the sequencer is back to idle
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while sequencer idle");

    // a division result only arrives while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_WAIT))
        else $error("division finished outside wait state");

    // the closing beat of a factored value always has a held factor to send
    a_flush_has_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH) |-> pend_valid_reg)
        else $error("flush without held factor");

    // a real factor beat carries a nonzero exponent and a prime of at least two
    a_factor_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_nof_reg) |-> (m_exp_reg != '0 && m_prime_reg >= pf_word_t'(2)))
        else $error("malformed factor beat");

    // a no-factors beat is always the single closing beat
    a_nof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_nof_reg) |-> m_last_reg)
        else $error("no-factors beat without last flag");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the trial-division prime factorizer
`timescale 1ns / 1ps

module testbench;
    import pf_pkg::*;

    // idle cycles with no accepted beat on either side before giving up; it must cover
    // the slowest item (a 24-bit prime) on its own
    localparam int WATCHDOG_LIMIT = 400_000;
    // cycles to keep watching the result side after the last expected beat
    localparam int DRAIN_CYCLES   = 200;
    // length of the receiver hold-off used to back the block up
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int MAX_PRINTS     = 100;
    localparam int RANDOM_ITEMS   = 72;

    // one result beat as the predictor sees it
    typedef struct {
        pf_word_t         prime_factor;
        logic [EXP_W-1:0] exponent;
        logic             no_factors;
        logic             last_factor;
    } factor_beat_t;

    logic                   aclk;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [VALUE_WIDTH-1:0] s_value        = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [VALUE_WIDTH-1:0] m_prime_factor;
    logic [EXP_W-1:0]       m_exponent;
    logic                   m_no_factors;
    logic                   m_last_factor;

    // factor beats predicted for accepted values, oldest first
    factor_beat_t expected_factors[$];
    int           mismatch_count = 0;
    // when set, neither side idles
    bit           calm           = 1'b0;
    // request from a test for one long receiver hold-off
    bit           rx_hold_req    = 1'b0;

    prime_factorizer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prime_factor (m_prime_factor),
        .m_exponent     (m_exponent),
        .m_no_factors   (m_no_factors),
        .m_last_factor  (m_last_factor)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // a roll comes out idle with a probability of 12 percent, unless a calm stretch is running
    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < 12);
    endfunction

    // expected factor beats for one value: trial divisors from 2 while d*d <= rest,
    // each dividing divisor taken out fully, leftover above 1 is a prime with exponent 1
    function automatic void predict_factors(input pf_word_t value);
        longint unsigned rest;
        longint unsigned divisor;
        int unsigned     mult;
        factor_beat_t    beat;
        factor_beat_t    run[$];
        rest    = value;
        divisor = 2;
        if (rest <= 1) begin
            // zero or one: a single beat flagged as having no factors
            beat.prime_factor = '0;
            beat.exponent     = '0;
            beat.no_factors   = 1'b1;
            beat.last_factor  = 1'b1;
            expected_factors.push_back(beat);
            return;
        end
        while (run.size() < MAX_RESULTS && divisor <= rest / divisor) begin
            if (rest % divisor == 0) begin
                mult = 0;
                while (rest % divisor == 0) begin
                    rest = rest / divisor;
                    if (mult < EXP_MAX) mult++;
                end
                beat.prime_factor = pf_word_t'(divisor);
                beat.exponent     = EXP_W'(mult);
                beat.no_factors   = 1'b0;
                beat.last_factor  = 1'b0;
                run.push_back(beat);
            end
            divisor++;
        end
        // prime left over after trial division
        if (run.size() < MAX_RESULTS && rest > 1) begin
            beat.prime_factor = pf_word_t'(rest);
            beat.exponent     = EXP_W'(1);
            beat.no_factors   = 1'b0;
            beat.last_factor  = 1'b0;
            run.push_back(beat);
        end
        run[run.size()-1].last_factor = 1'b1;
        foreach (run[i]) expected_factors.push_back(run[i]);
    endfunction

    // product of small primes, sometimes with a modest cofactor, kept to 24 bits
    function automatic pf_word_t smooth_value();
        int unsigned     small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37,
                                              41, 43, 47, 53, 59, 61, 67, 71, 73, 79, 83,
                                              89, 97};
        longint unsigned acc;
        longint unsigned p;
        int              picks;
        acc   = 1;
        picks = $urandom_range(12, 1);
        repeat (picks) begin
            p = small_primes[$urandom_range(24)];
            if (acc * p <= 64'hFF_FFFF) acc = acc * p;
        end
        if ($urandom_range(3) == 0) begin
            p = $urandom_range(60000, 2);
            if (acc * p <= 64'hFF_FFFF) acc = acc * p;
        end
        return pf_word_t'(acc);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // offer one value on the input side and predict its beats once it is taken;
    // valid is left high so the next call can follow on without a gap
    task automatic send_value(input pf_word_t value);
        while (idle_roll()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        predict_factors(value);
    endtask

    // result side ready: random idling, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                hold_left   = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !idle_roll();
            end
        end
    end

    // compare every accepted result beat with the oldest prediction
    initial begin : result_checker
        factor_beat_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_factors.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_prime_factor, 0);
                end else begin
                    want = expected_factors.pop_front();
                    if (m_prime_factor !== want.prime_factor)
                        report_mismatch("prime_factor", m_prime_factor, want.prime_factor);
                    if (m_exponent !== want.exponent)
                        report_mismatch("exponent", m_exponent, want.exponent);
                    if (m_no_factors !== want.no_factors)
                        report_mismatch("no_factors", m_no_factors, want.no_factors);
                    if (m_last_factor !== want.last_factor)
                        report_mismatch("last_factor", m_last_factor, want.last_factor);
                end
            end
        end
    end

    // ends the run when neither side moves a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // field extremes and the special cases: zero, one, prime leftover,
    // full set of distinct primes, largest exponent, largest prime
    task automatic test_directed();
        pf_word_t values[$];
        values = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd6, 24'd12, 24'd97, 24'd121,
                   24'd65536, 24'd8388608, 24'd14348907, 24'd15813251, 24'd9699690,
                   24'd11741730, 24'd16764928, 24'd16777214, 24'hAAAAAA, 24'h555555,
                   24'hFFFFFF, 24'd16777213};
        foreach (values[i]) send_value(values[i]);
    endtask

    // receiver stops for a long stretch while many-factor values keep coming,
    // so the output register fills, the search holds and s_ready drops
    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        send_value(24'd9699690);
        send_value(24'd11741730);
        repeat (6) send_value(smooth_value());
    endtask

    // mostly cheap values with rich factorizations, a few wide ones
    task automatic test_random();
        int       pick;
        pf_word_t value;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // a long stretch with no idling on either side
            calm = (i >= 40 && i < 70);
            pick = $urandom_range(99);
            if (pick < 55)      value = smooth_value();
            else if (pick < 80) value = pf_word_t'($urandom_range(65535));
            else if (pick < 92) value = pf_word_t'($urandom_range(40));
            else if (pick < 98) value = pf_word_t'($urandom_range(24'hFFFFF));
            else                value = pf_word_t'($urandom());
            send_value(value);
        end
        calm = 1'b0;
    endtask

    initial begin : main
        // synchronous reset held low, then released
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;

        // wait out every predicted beat, then watch a little longer for strays
        while (expected_factors.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_factors.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== prime_factorizer.f =====
sv/pf_pkg.sv
sv/pf_divider.sv
sv/prime_factorizer.sv
verif/testbench.sv
